FILE: rtl/csp_pkg.sv
// Shared types, constants and the sub-cell sequence table for the coverage
// sub-cell path expander. No dependencies.
`timescale 1ns / 1ps

package csp_pkg;

  localparam int COARSE_W   = 6;
  localparam int FINE_W     = COARSE_W + 1;
  localparam int COARSE_DIM = 64;
  localparam int MAX_SUB    = 4;
  localparam int CNT_W      = 3;

  localparam logic [COARSE_W-1:0] COORD_MAX =
    (COARSE_DIM >= (1 << COARSE_W)) ? COARSE_W'((1 << COARSE_W) - 1)
                                     : COARSE_W'(COARSE_DIM - 1);

  typedef enum logic [2:0] {
    MV_NONE  = 3'd0,
    MV_UP    = 3'd1,
    MV_DOWN  = 3'd2,
    MV_LEFT  = 3'd3,
    MV_RIGHT = 3'd4
  } move_t;

  // Sub-cell offset, coded as {dr, dc}.
  typedef logic [1:0] offs_t;

  typedef struct packed {
    logic [CNT_W-1:0]          count;
    offs_t [MAX_SUB-1:0]       offs;   // offs[0] leaves first
  } seq_t;

  typedef struct packed {
    logic                      valid;
    seq_t                      seq;
    logic [COARSE_W-1:0]       row;
    logic [COARSE_W-1:0]       col;
  } run_load_t;

  function automatic seq_t mk_seq(input logic [CNT_W-1:0] n, input offs_t a,
                                  input offs_t b, input offs_t c, input offs_t d);
    seq_t s;
    s.count = n;
    s.offs  = {d, c, b, a};
    return s;
  endfunction

  function automatic logic [COARSE_W-1:0] sat_coord(input logic [COARSE_W-1:0] v);
    return (v > COORD_MAX) ? COORD_MAX : v;
  endfunction

  // Order in which the sub-cells of the previous cell are visited (one to four
  // of them), chosen by the new move and the move that led into that cell.
  function automatic seq_t seq_lookup(input move_t mv, input move_t lm);
    seq_t s;
    s = '0;
    case (mv)
      MV_UP: begin
        case (lm)
          MV_NONE:  s = mk_seq(3'd2, 2'd3, 2'd1, 2'd0, 2'd0);
          MV_UP:    s = mk_seq(3'd2, 2'd3, 2'd1, 2'd0, 2'd0);
          MV_DOWN:  s = mk_seq(3'd4, 2'd0, 2'd2, 2'd3, 2'd1);
          MV_LEFT:  s = mk_seq(3'd1, 2'd1, 2'd0, 2'd0, 2'd0);
          MV_RIGHT: s = mk_seq(3'd3, 2'd2, 2'd3, 2'd1, 2'd0);
          default:  s = mk_seq(3'd2, 2'd3, 2'd1, 2'd0, 2'd0);
        endcase
      end
      MV_DOWN: begin
        case (lm)
          MV_NONE:  s = mk_seq(3'd2, 2'd0, 2'd2, 2'd0, 2'd0);
          MV_UP:    s = mk_seq(3'd4, 2'd3, 2'd1, 2'd0, 2'd2);
          MV_DOWN:  s = mk_seq(3'd2, 2'd0, 2'd2, 2'd0, 2'd0);
          MV_LEFT:  s = mk_seq(3'd3, 2'd1, 2'd0, 2'd2, 2'd0);
          MV_RIGHT: s = mk_seq(3'd1, 2'd2, 2'd0, 2'd0, 2'd0);
          default:  s = mk_seq(3'd2, 2'd0, 2'd2, 2'd0, 2'd0);
        endcase
      end
      MV_LEFT: begin
        case (lm)
          MV_NONE:  s = mk_seq(3'd2, 2'd1, 2'd0, 2'd0, 2'd0);
          MV_UP:    s = mk_seq(3'd2, 2'd1, 2'd0, 2'd0, 2'd0);
          MV_DOWN:  s = mk_seq(3'd1, 2'd0, 2'd0, 2'd0, 2'd0);
          MV_LEFT:  s = mk_seq(3'd2, 2'd1, 2'd0, 2'd0, 2'd0);
          MV_RIGHT: s = mk_seq(3'd4, 2'd2, 2'd3, 2'd1, 2'd0);
          default:  s = mk_seq(3'd2, 2'd1, 2'd0, 2'd0, 2'd0);
        endcase
      end
      MV_RIGHT: begin
        case (lm)
          MV_NONE:  s = mk_seq(3'd2, 2'd2, 2'd3, 2'd0, 2'd0);
          MV_UP:    s = mk_seq(3'd1, 2'd3, 2'd0, 2'd0, 2'd0);
          MV_DOWN:  s = mk_seq(3'd2, 2'd2, 2'd3, 2'd0, 2'd0);
          MV_LEFT:  s = mk_seq(3'd4, 2'd1, 2'd0, 2'd2, 2'd3);
          MV_RIGHT: s = mk_seq(3'd2, 2'd2, 2'd3, 2'd0, 2'd0);
          default:  s = mk_seq(3'd2, 2'd2, 2'd3, 2'd0, 2'd0);
        endcase
      end
      default: s = '0;
    endcase
    return s;
  endfunction

endpackage

FILE: rtl/csp_if.sv
// Valid/ready channel interfaces for the coarse-cell input and fine-cell output.
// Depends on csp_pkg for field widths.
`timescale 1ns / 1ps

interface csp_in_if;
  logic                             valid;
  logic                             ready;
  logic [csp_pkg::COARSE_W-1:0]     coarse_row;
  logic [csp_pkg::COARSE_W-1:0]     coarse_col;
  logic                             path_start;

  modport source (output valid, coarse_row, coarse_col, path_start, input ready);
  modport sink   (input valid, coarse_row, coarse_col, path_start, output ready);
endinterface

interface csp_out_if;
  logic                             valid;
  logic                             ready;
  logic [csp_pkg::FINE_W-1:0]       fine_row;
  logic [csp_pkg::FINE_W-1:0]       fine_col;
  logic                             last_of_run;

  modport source (output valid, fine_row, fine_col, last_of_run, input ready);
  modport sink   (input valid, fine_row, fine_col, last_of_run, output ready);
endinterface

FILE: rtl/csp_step.sv
// Walk history and move classification: keeps the previous coarse cell and the
// last move, and hands each sub-cell run to the emitter. Depends on csp_pkg, csp_if.
`timescale 1ns / 1ps

module csp_step (
  input  logic                clk,
  input  logic                rst_n,
  csp_in_if.sink              in_ch,
  input  logic                free_i,
  output csp_pkg::run_load_t  load_o
);
  import csp_pkg::*;

  logic [COARSE_W-1:0] prev_row_r, prev_row_nxt;
  logic [COARSE_W-1:0] prev_col_r, prev_col_nxt;
  logic                have_prev_r, have_prev_nxt;
  move_t               last_move_r, last_move_nxt;

  logic [COARSE_W-1:0] row_s, col_s;
  logic                accept;
  logic                restart;
  move_t               mv;

  assign in_ch.ready = free_i;
  assign accept      = in_ch.valid && in_ch.ready;
  assign row_s       = sat_coord(in_ch.coarse_row);
  assign col_s       = sat_coord(in_ch.coarse_col);
  assign restart     = in_ch.path_start || !have_prev_r;

  // Row decides first; equal cells fall through to a right move.
  always_comb begin
    if (prev_row_r > row_s)       mv = MV_UP;
    else if (prev_row_r < row_s)  mv = MV_DOWN;
    else if (prev_col_r > col_s)  mv = MV_LEFT;
    else                          mv = MV_RIGHT;
  end

  always_comb begin
    prev_row_nxt  = prev_row_r;
    prev_col_nxt  = prev_col_r;
    have_prev_nxt = have_prev_r;
    last_move_nxt = last_move_r;
    load_o.valid  = accept && !restart;
    load_o.seq    = seq_lookup(mv, last_move_r);
    load_o.row    = prev_row_r;
    load_o.col    = prev_col_r;
    if (accept) begin
      prev_row_nxt  = row_s;
      prev_col_nxt  = col_s;
      have_prev_nxt = 1'b1;
      last_move_nxt = restart ? MV_NONE : mv;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_row_r  <= '0;
      prev_col_r  <= '0;
      have_prev_r <= 1'b0;
      last_move_r <= MV_NONE;
    end else begin
      prev_row_r  <= prev_row_nxt;
      prev_col_r  <= prev_col_nxt;
      have_prev_r <= have_prev_nxt;
      last_move_r <= last_move_nxt;
    end
  end

endmodule

FILE: rtl/csp_emit.sv
// Run register: holds one sub-cell run and sends it out on the result channel,
// one fine cell per cycle while out_ch.ready is high. Depends on csp_pkg, csp_if.
`timescale 1ns / 1ps

module csp_emit (
  input  logic                clk,
  input  logic                rst_n,
  input  csp_pkg::run_load_t  load_i,
  output logic                free_o,
  csp_out_if.source           out_ch
);
  import csp_pkg::*;

  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  offs_t [MAX_SUB-1:0]   offs_r, offs_nxt;
  logic [COARSE_W-1:0]   row_r, row_nxt;
  logic [COARSE_W-1:0]   col_r, col_nxt;
  logic                  pop;

  assign pop    = out_ch.valid && out_ch.ready;
  // The register can take a new run while the final sub-cell of the old one leaves.
  assign free_o = (cnt_r == '0) || ((cnt_r == CNT_W'(1)) && out_ch.ready);

  assign out_ch.valid       = (cnt_r != '0);
  assign out_ch.fine_row    = {row_r, offs_r[0][1]};
  assign out_ch.fine_col    = {col_r, offs_r[0][0]};
  assign out_ch.last_of_run = (cnt_r == CNT_W'(1));

  always_comb begin
    cnt_nxt  = cnt_r;
    offs_nxt = offs_r;
    row_nxt  = row_r;
    col_nxt  = col_r;
    if (load_i.valid) begin
      cnt_nxt  = load_i.seq.count;
      offs_nxt = load_i.seq.offs;
      row_nxt  = load_i.row;
      col_nxt  = load_i.col;
    end else if (pop) begin
      cnt_nxt  = cnt_r - CNT_W'(1);
      offs_nxt = {2'b00, offs_r[MAX_SUB-1:1]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    offs_r <= offs_nxt;
    row_r  <= row_nxt;
    col_r  <= col_nxt;
  end

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_SUB))
    else $error("run count above four sub-cells");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    load_i.valid |-> (cnt_r == '0) || ((cnt_r == CNT_W'(1)) && out_ch.ready))
    else $error("new run loaded over a run still in flight");

  a_load_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    load_i.valid |-> (load_i.seq.count != '0))
    else $error("loaded run carries no sub-cells");

  a_pop_step: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !load_i.valid) |=> (cnt_r == $past(cnt_r) - CNT_W'(1)))
    else $error("run count did not step down after a request was taken");
`endif

endmodule

FILE: rtl/coverage_subcell_path_expander_core.sv
// Top level of the coverage sub-cell path expander: walk history stage and
// run register. Depends on csp_pkg, csp_if, csp_step and csp_emit.
`timescale 1ns / 1ps

// Usage
//   in_ch  : coarse cells of a coverage walk (coarse_row, coarse_col, path_start),
//            valid/ready. A request with path_start set, or the first after reset,
//            only records the cell and gives no result.
//   out_ch : fine sub-cells (fine_row, fine_col, last_of_run) of the previous
//            coarse cell, one to four per input request, last_of_run on the final.
// The first sub-cell of an input appears in the cycle after it is accepted.
// Throughput: one fine cell per cycle on the output while out_ch.ready is high; an
//   input producing n sub-cells (up to four) occupies the run register until all n
//   have left, so an input is not taken while a run is in flight. The next input is
//   accepted in the same cycle as the final sub-cell of the current run leaves, and
//   cells that give no result are accepted whenever the run register is free.
// Reset (rst_n low, synchronous): history and run register clear, no path open.
// Output stall: the run register holds its sub-cell until out_ch.ready, and
//   in_ch.ready stays low until the final sub-cell of the run can leave.
module coverage_subcell_path_expander_core (
  input  logic       clk,
  input  logic       rst_n,
  csp_in_if.sink     in_ch,
  csp_out_if.source  out_ch
);
  import csp_pkg::*;

  run_load_t load;
  logic      free;

  csp_step u_step (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .free_i (free),
    .load_o (load)
  );

  csp_emit u_emit (
    .clk    (clk),
    .rst_n  (rst_n),
    .load_i (load),
    .free_o (free),
    .out_ch (out_ch)
  );

endmodule
